// ===== hdl/smh_pkg.sv =====
package smh_pkg;

  // data path widths
  localparam int WORD_W = 64;
  localparam int HALF_W = 32;
  localparam int CFG_W  = 32;

  // default vector length width
  localparam int LENGTH_BITS_DEF = 32;

  // splitmix64 constants
  localparam logic [WORD_W-1:0] GOLDEN  = 64'h9e3779b97f4a7c15;
  localparam logic [WORD_W-1:0] SM_MUL1 = 64'hbf58476d1ce4e5b9;
  localparam logic [WORD_W-1:0] SM_MUL2 = 64'h94d049bb133111eb;

  // per-word step constants
  localparam logic [WORD_W-1:0] STEP_MUL = 64'h165667919e3779f9;
  localparam logic [WORD_W-1:0] STEP_ADD = 64'h9e3779b97f4a7c15;

  // murmur3 finalizer constants
  localparam logic [WORD_W-1:0] FIN_MUL1 = 64'hff51afd7ed558ccd;
  localparam logic [WORD_W-1:0] FIN_MUL2 = 64'hc4ceb9fe1a85ec53;

endpackage

// ===== hdl/sign_mask_hash.sv =====
// a non-final word runs the MIX1, MIX2 and STEP multiplies; the input stalls until it returns to idle
// a final word also runs FIN1 and FIN2, the hash beat is shown on the output after that
// all multiplies go through one shared 32x32 multiplier: 5 products per final word
// reset (rst, synchronous): vector length = 1, running hash reseeded, word index cleared
// after a final word the input stays stalled until the output register is free
module sign_mask_hash #(
  parameter int LENGTH_BITS = smh_pkg::LENGTH_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       write_enable,
  input  logic [smh_pkg::CFG_W-1:0]  write_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [smh_pkg::WORD_W-1:0] sign_word,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [smh_pkg::WORD_W-1:0] hash_value
);

  localparam int WW    = smh_pkg::WORD_W;
  localparam int IDX_W = LENGTH_BITS - 6;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_MIX1 = 7'b0000010,
    S_MIX2 = 7'b0000100,
    S_STEP = 7'b0001000,
    S_FIN1 = 7'b0010000,
    S_FIN2 = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t state;
  logic [LENGTH_BITS-1:0] vec_length;
  logic [IDX_W-1:0]       word_index;
  logic [WW-1:0]          running_hash;
  logic [WW-1:0]          work;
  logic                   last_word;
  logic                   go;

  logic                   accept;
  logic                   out_load;
  logic [LENGTH_BITS-1:0] base;
  logic [LENGTH_BITS-1:0] rem;
  logic                   full_word;
  logic [WW-1:0]          masked_word;
  logic [WW-1:0]          tag;
  logic [WW-1:0]          mul_b;
  logic                   mul_done;
  logic [WW-1:0]          mul_p;
  logic [WW-1:0]          mixed;
  logic [WW-1:0]          stepped;
  logic [WW-1:0]          seed;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign out_load = (state == S_OUT) && (!out_valid || !out_stall);
  assign seed     = smh_pkg::GOLDEN ^ WW'(vec_length);

  // tail masking and position tag
  always_comb begin
    base        = {word_index, 6'd0};
    rem         = (vec_length > base) ? (vec_length - base) : '0;
    full_word   = (rem[LENGTH_BITS-1:6] != '0);
    masked_word = sign_word & ~({WW{1'b1}} << rem[5:0]);
    if (full_word) begin
      masked_word = sign_word;
      tag         = WW'({word_index, 6'h3f});
    end else begin
      tag         = WW'(vec_length);
    end
  end

  // constant operand for the shared multiplier
  always_comb begin
    case (state)
      S_MIX1:  mul_b = smh_pkg::SM_MUL1;
      S_MIX2:  mul_b = smh_pkg::SM_MUL2;
      S_STEP:  mul_b = smh_pkg::STEP_MUL;
      S_FIN1:  mul_b = smh_pkg::FIN_MUL1;
      S_FIN2:  mul_b = smh_pkg::FIN_MUL2;
      default: mul_b = smh_pkg::STEP_MUL;
    endcase
  end

  // multiplier operand a is the shifted-xor form where the mix calls for it
  logic [WW-1:0] mul_a;
  always_comb begin
    case (state)
      S_MIX1:  mul_a = work ^ (work >> 30);
      S_MIX2:  mul_a = work ^ (work >> 27);
      default: mul_a = work;
    endcase
  end

  smh_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .go      (go),
    .a       (mul_a),
    .b       (mul_b),
    .done    (mul_done),
    .product (mul_p)
  );

  // post-multiply steps
  always_comb begin
    mixed   = running_hash ^ (mul_p ^ (mul_p >> 31));
    stepped = mul_p + smh_pkg::STEP_ADD;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      go           <= 1'b0;
      vec_length   <= LENGTH_BITS'(1);
      word_index   <= '0;
      running_hash <= smh_pkg::GOLDEN ^ WW'(1);
    end else begin
      go <= 1'b0;
      if (write_enable) begin
        vec_length   <= LENGTH_BITS'(WW'(write_data));
        word_index   <= '0;
        running_hash <= smh_pkg::GOLDEN ^ WW'(LENGTH_BITS'(WW'(write_data)));
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            work      <= (masked_word ^ tag) + smh_pkg::GOLDEN;
            last_word <= !full_word || (rem == LENGTH_BITS'(64));
            go        <= 1'b1;
            state     <= S_MIX1;
          end
        end
        S_MIX1: begin
          if (mul_done) begin
            work  <= mul_p;
            go    <= 1'b1;
            state <= S_MIX2;
          end
        end
        S_MIX2: begin
          if (mul_done) begin
            work  <= {mixed[WW-28:0], mixed[WW-1:WW-27]};
            go    <= 1'b1;
            state <= S_STEP;
          end
        end
        S_STEP: begin
          if (mul_done) begin
            if (last_word) begin
              work  <= stepped ^ (stepped >> 33);
              go    <= 1'b1;
              state <= S_FIN1;
            end else begin
              running_hash <= stepped;
              word_index   <= word_index + IDX_W'(1);
              state        <= S_IDLE;
            end
          end
        end
        S_FIN1: begin
          if (mul_done) begin
            work  <= mul_p ^ (mul_p >> 33);
            go    <= 1'b1;
            state <= S_FIN2;
          end
        end
        S_FIN2: begin
          if (mul_done) begin
            work  <= mul_p ^ (mul_p >> 33);
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            running_hash <= seed;
            word_index   <= '0;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) hash_value <= work;
  end

`ifndef SYNTHESIS
  // a new result beat only comes out of the output-wait state
  a_out_from_wait: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !$past(out_valid)) |-> $past(state == S_OUT))
    else $error("result appeared without passing the output wait state");

  // multiplier completes only while a multiply state waits for it
  a_done_in_mul_state: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> (state == S_MIX1 || state == S_MIX2 || state == S_STEP ||
                  state == S_FIN1 || state == S_FIN2))
    else $error("multiplier done outside a multiply state");

  // start is a single-cycle pulse
  a_go_pulse: assert property (@(posedge clk) disable iff (rst)
    go |=> !go)
    else $error("multiplier start held for more than one cycle");

  // running hash untouched while mixing or finalizing, unless the length register is written
  a_hash_hold: assert property (@(posedge clk) disable iff (rst)
    ((state == S_MIX1 || state == S_MIX2 || state == S_FIN1 || state == S_FIN2) &&
     !write_enable) |=> $stable(running_hash))
    else $error("running hash changed mid-word");
`endif

endmodule

// ===== hdl/smh_mul.sv =====
module smh_mul (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       go,
  input  logic [smh_pkg::WORD_W-1:0] a,
  input  logic [smh_pkg::WORD_W-1:0] b,
  output logic                       done,
  output logic [smh_pkg::WORD_W-1:0] product
);

  localparam int HW = smh_pkg::HALF_W;
  localparam int WW = smh_pkg::WORD_W;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_LH   = 4'b0010,
    PH_HL   = 4'b0100,
    PH_SUM  = 4'b1000
  } phase_t;

  phase_t phase;
  logic [HW-1:0] mul_a;
  logic [HW-1:0] mul_b;
  logic [WW-1:0] prod;
  logic [WW-1:0] acc;

  // operand halves for the current partial product
  always_comb begin
    case (phase)
      PH_LH: begin
        mul_a = a[HW-1:0];
        mul_b = b[WW-1:HW];
      end
      PH_HL: begin
        mul_a = a[WW-1:HW];
        mul_b = b[HW-1:0];
      end
      default: begin
        mul_a = a[HW-1:0];
        mul_b = b[HW-1:0];
      end
    endcase
  end

  // phase sequencer, low 64 bits of a 64x64 product in three partial products
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      done  <= 1'b0;
    end else begin
      done <= (phase == PH_SUM);
      case (phase)
        PH_IDLE: if (go) phase <= PH_LH;
        PH_LH:   phase <= PH_HL;
        PH_HL:   phase <= PH_SUM;
        PH_SUM:  phase <= PH_IDLE;
        default: phase <= PH_IDLE;
      endcase
    end
  end

  // shared 32x32 multiplier and accumulator
  always_ff @(posedge clk) begin
    prod <= {{HW{1'b0}}, mul_a} * {{HW{1'b0}}, mul_b};
    case (phase)
      PH_LH:   acc <= prod;
      PH_HL:   acc[WW-1:HW] <= acc[WW-1:HW] + prod[HW-1:0];
      PH_SUM:  acc[WW-1:HW] <= acc[WW-1:HW] + prod[HW-1:0];
      default: acc <= acc;
    endcase
  end

  assign product = acc;

endmodule
